/* hw/rtl/aes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants and byte/column functions of the AES round datapath and
// the key expansion: S-box tables, GF(2^8) doubling and MixColumns.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int RoundKeyWordsDefault = 60;
  localparam int NumCfgRegs = 5;

  // register indexes of the configuration port
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_KEY0 = 3'd1;
  localparam logic [2:0] REG_KEY1 = 3'd2;
  localparam logic [2:0] REG_KEY2 = 3'd3;
  localparam logic [2:0] REG_KEY3 = 3'd4;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_REDUCE  = 8'h1b;

  // forward S-box, entry 0 in the top byte
  localparam logic [2047:0] SBOX_BITS = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  // inverse S-box, entry 0 in the top byte
  localparam logic [2047:0] RSBOX_BITS = {
    128'h52096ad53036a538bf40a39e81f3d7fb,
    128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e,
    128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692,
    128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506,
    128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673,
    128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b,
    128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f,
    128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961,
    128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_BITS[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] rsbox(input logic [7:0] x);
    return RSBOX_BITS[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // column byte r sits in bits 8r+7:8r
  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) a[k] = w[8*k +: 8];
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = xtime(a[k]) ^ xtime(a[(k+1)%4]) ^ a[(k+1)%4]
                  ^ a[(k+2)%4] ^ a[(k+3)%4];
    end
    return r;
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[8*k +: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
    end
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = (x8[k] ^ x4[k] ^ x2[k])
                  ^ (x8[(k+1)%4] ^ x2[(k+1)%4] ^ a[(k+1)%4])
                  ^ (x8[(k+2)%4] ^ x4[(k+2)%4] ^ a[(k+2)%4])
                  ^ (x8[(k+3)%4] ^ a[(k+3)%4]);
    end
    return r;
  endfunction

  // shift rows and substitute, then mix unless last round
  function automatic logic [127:0] enc_round(input logic [127:0] st, input logic last);
    logic [127:0] t;
    logic [127:0] m;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(r+4*c) +: 8] = sbox(st[8*(r+4*((c+r)%4)) +: 8]);
    for (int c = 0; c < 4; c++) m[32*c +: 32] = mix_col(t[32*c +: 32]);
    return last ? t : m;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] st, input logic last);
    logic [127:0] t;
    logic [127:0] m;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(r+4*c) +: 8] = rsbox(st[8*(r+4*((c+4-r)%4)) +: 8]);
    for (int c = 0; c < 4; c++) m[32*c +: 32] = inv_mix_col(t[32*c +: 32]);
    return last ? t : m;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/aes_block_cipher_128_256.sv */
// Pipeline: one stage per round plus the initial key add.
// Throughput: one block per cycle while out_ready and the key expansion allow it, both directions mixed freely.
// Reset and every mode or key register write start the key expansion, one word
//   a cycle: 44 words for AES-128, 60 for AES-256; in_ready is low meanwhile.
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_cipher_128_256
// Pipelined AES-128/256 encrypt and decrypt with a sequential key expander
// that fills the encryption and equivalent-inverse decryption key words.
// ----------------------------------------------------------------------------
module aes_block_cipher_128_256
  import aes_pkg::*;
#(
  parameter int ROUND_KEY_WORDS = RoundKeyWordsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [63:0] block_low,
  input  wire logic [63:0] block_high,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_low,
  output logic [63:0]      result_high
);

  localparam bit WIDE_OK = (ROUND_KEY_WORDS >= 60);
  localparam int NR_MAX  = WIDE_OK ? 14 : 10;
  localparam int KW_BITS = $clog2(ROUND_KEY_WORDS);

  // configuration registers
  logic        mode;
  logic [63:0] key_regs [4];
  logic        wide;

  assign wide = mode & WIDE_OK;

  // key expansion state
  logic               busy;
  logic [KW_BITS-1:0] cnt;
  logic [7:0]         rc;
  logic [31:0]        win [8];
  logic [31:0]        enc_rk [ROUND_KEY_WORDS];
  logic [31:0]        dec_rk [ROUND_KEY_WORDS];

  logic               cfg_hit;
  logic [KW_BITS-1:0] total;
  logic               seed_word;
  logic               rcon_step;
  logic [31:0]        t_word;
  logic [31:0]        new_word;
  logic [31:0]        dec_word;
  logic [63:0]        seed_reg;

  assign cfg_hit = cfg_write && (cfg_index <= REG_KEY3);
  assign total   = wide ? KW_BITS'(60) : KW_BITS'(44);

  // next expanded word
  always_comb begin
    seed_word = wide ? (cnt < KW_BITS'(8)) : (cnt < KW_BITS'(4));
    rcon_step = wide ? (cnt[2:0] == 3'd0) : (cnt[1:0] == 2'd0);
    seed_reg  = key_regs[cnt[2:1]];
    t_word    = win[7];
    if (rcon_step) begin
      t_word = sub_word({win[7][7:0], win[7][31:8]}) ^ {24'd0, rc};
    end else if (wide && cnt[2:0] == 3'd4) begin
      t_word = sub_word(win[7]);
    end
    if (seed_word) begin
      new_word = cnt[0] ? seed_reg[63:32] : seed_reg[31:0];
    end else begin
      new_word = (wide ? win[0] : win[4]) ^ t_word;
    end
    if (cnt < KW_BITS'(4) || cnt >= total - KW_BITS'(4)) begin
      dec_word = new_word;
    end else begin
      dec_word = inv_mix_col(new_word);
    end
  end

  // configuration writes and expander control
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      for (int k = 0; k < 4; k++) key_regs[k] <= 64'd0;
      busy <= 1'b1;
      cnt  <= '0;
      rc   <= RCON_FIRST;
    end else if (cfg_hit) begin
      if (cfg_index == REG_MODE) begin
        mode <= cfg_data[0];
      end else begin
        key_regs[2'(cfg_index - REG_KEY0)] <= cfg_data;
      end
      busy <= 1'b1;
      cnt  <= '0;
      rc   <= RCON_FIRST;
    end else if (busy) begin
      if (!seed_word && rcon_step) rc <= xtime(rc);
      cnt <= cnt + 1'b1;
      if (cnt == total - 1'b1) busy <= 1'b0;
    end
  end

  // key word storage and sliding window
  always_ff @(posedge clk) begin
    if (busy && !cfg_hit) begin
      enc_rk[cnt] <= new_word;
      dec_rk[cnt] <= dec_word;
      for (int k = 0; k < 7; k++) win[k] <= win[k+1];
      win[7] <= new_word;
    end
  end

  // round pipeline
  logic         advance;
  logic [3:0]   nr;
  logic [127:0] st  [NR_MAX+1];
  logic         act [NR_MAX+1];
  logic         vld [NR_MAX+1];

  assign advance  = !vld[NR_MAX] || out_ready;
  assign in_ready = advance && !busy;
  assign nr       = wide ? 4'd14 : 4'd10;

  // stage 0: initial key add
  logic [127:0] key0;
  always_comb begin
    key0 = {enc_rk[3], enc_rk[2], enc_rk[1], enc_rk[0]};
    if (action) begin
      if (wide) begin
        key0 = {dec_rk[4*NR_MAX+3], dec_rk[4*NR_MAX+2],
                dec_rk[4*NR_MAX+1], dec_rk[4*NR_MAX]};
      end else begin
        key0 = {dec_rk[43], dec_rk[42], dec_rk[41], dec_rk[40]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0]  <= {block_high, block_low} ^ key0;
      act[0] <= action;
    end
  end

  // one round per stage; stages past the last round pass the state through
  for (genvar s = 1; s <= NR_MAX; s++) begin : g_round
    localparam int KE  = s;
    localparam int KDW = (NR_MAX == 14) ? 14 - s : 0;
    localparam int KDN = (s <= 10) ? 10 - s : 0;

    logic         full_rnd;
    logic         last_rnd;
    logic [127:0] rk;
    logic [127:0] nxt;

    always_comb begin
      full_rnd = 4'(s) < nr;
      last_rnd = 4'(s) == nr;
      if (!act[s-1]) begin
        rk = {enc_rk[4*KE+3], enc_rk[4*KE+2], enc_rk[4*KE+1], enc_rk[4*KE]};
      end else if (wide) begin
        rk = {dec_rk[4*KDW+3], dec_rk[4*KDW+2], dec_rk[4*KDW+1], dec_rk[4*KDW]};
      end else begin
        rk = {dec_rk[4*KDN+3], dec_rk[4*KDN+2], dec_rk[4*KDN+1], dec_rk[4*KDN]};
      end
      if (full_rnd || last_rnd) begin
        nxt = (act[s-1] ? dec_round(st[s-1], last_rnd) : enc_round(st[s-1], last_rnd)) ^ rk;
      end else begin
        nxt = st[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (advance) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st[s]  <= nxt;
        act[s] <= act[s-1];
      end
    end
  end

  assign out_valid   = vld[NR_MAX];
  assign result_low  = st[NR_MAX][63:0];
  assign result_high = st[NR_MAX][127:64];

endmodule
`default_nettype wire

/* hw/rtl/aes_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks of the cipher: result beat holding, key expansion
// blocking input, and input ready only when the pipe can move.
// ----------------------------------------------------------------------------
module aes_checker
  import aes_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_write,
  input wire logic [2:0]  cfg_index,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] result_low,
  input wire logic [63:0] result_high
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_low) && $stable(result_high))
    else $error("result beat changed while stalled");

  // expansion after reset blocks input
  a_reset_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken right after reset");

  // mode or key write restarts expansion
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_index <= REG_KEY3 |=> !in_ready)
    else $error("input taken right after key write");

  // input only when the pipe can advance
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input ready while output stalled");

endmodule

bind aes_block_cipher_128_256 aes_checker u_aes_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_write  (cfg_write),
  .cfg_index  (cfg_index),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .result_low (result_low),
  .result_high(result_high)
);
`default_nettype wire
